// ===== hdl/tkh_pkg.sv =====
// Shared types and constants for the top-K selection store.
// Used by the datapath, controller, top level and checker.
package tkh_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = 4;
  localparam int CNT_W    = 5;
  localparam int POS_W    = 6;

  typedef struct packed {
    logic [31:0] score;
    logic [31:0] mass_right;
    logic [31:0] mass_left;
    logic [63:0] mod_key;
    logic [63:0] tag_key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam logic [1:0] ACT_PUSH   = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [2:0] ST_REJECTED = 3'd0;
  localparam logic [2:0] ST_APPENDED = 3'd1;
  localparam logic [2:0] ST_REPLACED = 3'd2;
  localparam logic [2:0] ST_RAISED   = 3'd3;
  localparam logic [2:0] ST_KEPT     = 3'd4;
  localparam logic [2:0] ST_CLEARED  = 3'd5;
  localparam logic [2:0] ST_READ_OK  = 3'd6;
  localparam logic [2:0] ST_BAD_IDX  = 3'd7;

  // Store write data sources.
  localparam logic [1:0] WS_CUR   = 2'd0;
  localparam logic [1:0] WS_LEFT  = 2'd1;
  localparam logic [1:0] WS_RDATA = 2'd2;
  localparam logic [1:0] WS_ITEM  = 2'd3;

  // Sources of the moving entry register.
  localparam logic [1:0] CS_ITEM  = 2'd0;
  localparam logic [1:0] CS_RAISE = 2'd1;
  localparam logic [1:0] CS_RDATA = 2'd2;

  typedef struct packed {
    logic             item_ld;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [1:0]       wr_sel;
    logic             cur_ld;
    logic [1:0]       cur_sel;
    logic             lreg_ld;
    logic             out_ld;
    logic             out_rd;
    logic [2:0]       out_status;
    logic [CNT_W-1:0] out_count;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       act;
    logic [IDX_W-1:0] ri;
    logic             match;
    logic             item_gt_rd;
    logic             cur_gt_rd;
    logic             cur_gt_l;
    logic             l_lt_rd;
    logic             rd_gt_cur;
    logic             out_full;
  } stat_t;

endpackage

// ===== hdl/top_k_heap_with_dedup.sv =====
// Top-K selection store with duplicate merging. One item at a time; a push scans the held
// entries for a duplicate and then appends or sifts down the heap, paced by the single read
// port of the entry store. The push that fills the store adds an insertion sort. Synchronous
// reset empties the store and sets K to 16; no clearing pass runs. Depends on tkh_pkg,
// tkh_ctrl and tkh_datapath.
module top_k_heap_with_dedup (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [4:0]   cfg_data,        // capacity_in_use
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tag_key, mod_key, mass_left, mass_right, score, read_index, zero fill
  input  logic [231:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,    // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // entry_count, out_tag_key, out_mod_key, out_mass_left, out_mass_right, out_score, zero fill
  output logic [231:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser     // status
);

  tkh_pkg::cmd_t  cmd;
  tkh_pkg::stat_t stat;

  tkh_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .s_tvalid(s_axis_tvalid),
    .s_tready(s_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  tkh_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_axis_tdata),
    .s_tuser (s_axis_tuser),
    .cmd     (cmd),
    .stat    (stat),
    .m_tvalid(m_axis_tvalid),
    .m_tready(m_axis_tready),
    .m_tdata (m_axis_tdata),
    .m_tuser (m_axis_tuser)
  );

endmodule

// ===== hdl/tkh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tkh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/tkh_datapath.sv =====
// Datapath: item register, entry store, sift registers, compares and result register.
// Depends on tkh_pkg and tkh_ram.
module tkh_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic [231:0]        s_tdata,
  input  logic [1:0]          s_tuser,
  input  tkh_pkg::cmd_t       cmd,
  output tkh_pkg::stat_t      stat,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [231:0]        m_tdata,
  output logic [2:0]          m_tuser
);

  tkh_pkg::entry_t                 item;
  logic [1:0]                      act;
  logic [tkh_pkg::IDX_W-1:0]       ri;
  tkh_pkg::entry_t                 cur;
  tkh_pkg::entry_t                 lreg;
  tkh_pkg::entry_t                 rdata;
  tkh_pkg::entry_t                 wdata;
  tkh_pkg::entry_t                 raised;
  logic [tkh_pkg::ENTRY_W-1:0]     rdata_raw;
  logic                            out_valid;
  tkh_pkg::entry_t                 out_entry;
  logic [tkh_pkg::CNT_W-1:0]       out_count;
  logic [2:0]                      out_status;

  tkh_ram #(
    .WIDTH(tkh_pkg::ENTRY_W),
    .DEPTH(tkh_pkg::CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(cmd.wr_addr),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(cmd.rd_addr),
    .rdata(rdata_raw)
  );

  assign rdata = tkh_pkg::entry_t'(rdata_raw);

  always_comb begin
    raised       = rdata;
    raised.score = item.score;
  end

  always_comb begin
    unique case (cmd.wr_sel)
      tkh_pkg::WS_CUR:   wdata = cur;
      tkh_pkg::WS_LEFT:  wdata = lreg;
      tkh_pkg::WS_RDATA: wdata = rdata;
      default:           wdata = item;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.item_ld) begin
      item <= tkh_pkg::entry_t'(s_tdata[tkh_pkg::ENTRY_W-1:0]);
      ri   <= s_tdata[tkh_pkg::ENTRY_W +: tkh_pkg::IDX_W];
      act  <= s_tuser;
    end
    if (cmd.cur_ld) begin
      unique case (cmd.cur_sel)
        tkh_pkg::CS_ITEM:  cur <= item;
        tkh_pkg::CS_RAISE: cur <= raised;
        default:           cur <= rdata;
      endcase
    end
    if (cmd.lreg_ld) begin
      lreg <= rdata;
    end
    if (cmd.out_ld) begin
      out_entry  <= cmd.out_rd ? rdata : '0;
      out_count  <= cmd.out_count;
      out_status <= cmd.out_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    stat.act        = act;
    stat.ri         = ri;
    stat.match      = (rdata.tag_key == item.tag_key) && (rdata.mod_key == item.mod_key) &&
                      (rdata.mass_left == item.mass_left) &&
                      (rdata.mass_right == item.mass_right);
    stat.item_gt_rd = item.score > rdata.score;
    stat.cur_gt_rd  = cur.score > rdata.score;
    stat.cur_gt_l   = cur.score > lreg.score;
    stat.l_lt_rd    = lreg.score < rdata.score;
    stat.rd_gt_cur  = rdata.score > cur.score;
    stat.out_full   = out_valid;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_entry, out_count};
  assign m_tuser  = out_status;

endmodule

// ===== hdl/tkh_ctrl.sv =====
// Controller: sequences duplicate scan, append, fill-time sort, sift-down and reads.
// Depends on tkh_pkg; drives the datapath through cmd_t and watches stat_t.
module tkh_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [4:0]                cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  tkh_pkg::stat_t            stat,
  output tkh_pkg::cmd_t             cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISP     = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CMP = 4'd3;
  localparam logic [3:0] S_ROOT_CMP = 4'd4;
  localparam logic [3:0] S_SIFT_RL  = 4'd5;
  localparam logic [3:0] S_SIFT_CL  = 4'd6;
  localparam logic [3:0] S_SIFT_CR  = 4'd7;
  localparam logic [3:0] S_SORT_RI  = 4'd8;
  localparam logic [3:0] S_SORT_LI  = 4'd9;
  localparam logic [3:0] S_SORT_RJ  = 4'd10;
  localparam logic [3:0] S_SORT_CJ  = 4'd11;
  localparam logic [3:0] S_READ_WT  = 4'd12;
  localparam logic [3:0] S_FIN      = 4'd13;

  localparam int CW = tkh_pkg::CNT_W;
  localparam int PW = tkh_pkg::POS_W;
  localparam int IW = tkh_pkg::IDX_W;

  logic [3:0]    state, state_next;
  logic [CW-1:0] cap;
  logic [CW-1:0] held, held_next;
  logic [CW-1:0] idx, idx_next;    // scan index, sort outer index
  logic [CW-1:0] jdx, jdx_next;    // sort hole position
  logic [PW-1:0] pos, pos_next;    // sift hole position
  logic [CW-1:0] lim, lim_next;    // sift bound
  logic [2:0]    code, code_next;
  logic          rdout, rdout_next;

  logic [CW-1:0] kk;
  logic          full;
  logic [PW-1:0] lpos, rpos;
  logic          lsm, rsm;

  always_comb begin
    if (cap < CW'(2)) begin
      kk = CW'(2);
    end else if (cap > CW'(tkh_pkg::CAPACITY)) begin
      kk = CW'(tkh_pkg::CAPACITY);
    end else begin
      kk = cap;
    end
  end

  assign full = held >= kk;
  assign lpos = {pos[PW-2:0], 1'b1};
  assign rpos = lpos + PW'(1);
  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    held_next  = held;
    idx_next   = idx;
    jdx_next   = jdx;
    pos_next   = pos;
    lim_next   = lim;
    code_next  = code;
    rdout_next = rdout;
    lsm        = 1'b0;
    rsm        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.item_ld = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        rdout_next = 1'b0;
        priority case (stat.act)
          tkh_pkg::ACT_PUSH: begin
            idx_next   = '0;
            state_next = S_SCAN_RD;
          end
          tkh_pkg::ACT_CLEAR: begin
            held_next  = '0;
            code_next  = tkh_pkg::ST_CLEARED;
            state_next = S_FIN;
          end
          tkh_pkg::ACT_READ: begin
            if ({1'b0, stat.ri} < held) begin
              cmd.rd_en   = 1'b1;
              cmd.rd_addr = stat.ri;
              code_next   = tkh_pkg::ST_READ_OK;
              rdout_next  = 1'b1;
              state_next  = S_READ_WT;
            end else begin
              code_next  = tkh_pkg::ST_BAD_IDX;
              state_next = S_FIN;
            end
          end
          default: begin
            code_next  = tkh_pkg::ST_REJECTED;
            state_next = S_FIN;
          end
        endcase
      end
      S_READ_WT: state_next = S_FIN;
      S_SCAN_RD: begin
        if (idx < held) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = idx[IW-1:0];
          state_next  = S_SCAN_CMP;
        end else if (!full) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = held[IW-1:0];
          cmd.wr_sel  = tkh_pkg::WS_ITEM;
          held_next   = held + CW'(1);
          code_next   = tkh_pkg::ST_APPENDED;
          if (held + CW'(1) == kk) begin
            idx_next   = CW'(1);
            state_next = S_SORT_RI;
          end else begin
            state_next = S_FIN;
          end
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = '0;
          state_next  = S_ROOT_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (stat.match) begin
          if (stat.item_gt_rd) begin
            // Raised entry sifts only when the store is full; else it is written back.
            cmd.cur_ld  = 1'b1;
            cmd.cur_sel = tkh_pkg::CS_RAISE;
            pos_next    = {1'b0, idx};
            lim_next    = full ? kk : '0;
            code_next   = tkh_pkg::ST_RAISED;
            state_next  = S_SIFT_RL;
          end else begin
            code_next  = tkh_pkg::ST_KEPT;
            state_next = S_FIN;
          end
        end else begin
          idx_next   = idx + CW'(1);
          state_next = S_SCAN_RD;
        end
      end
      S_ROOT_CMP: begin
        if (stat.item_gt_rd) begin
          cmd.cur_ld  = 1'b1;
          cmd.cur_sel = tkh_pkg::CS_ITEM;
          pos_next    = '0;
          lim_next    = kk;
          code_next   = tkh_pkg::ST_REPLACED;
          state_next  = S_SIFT_RL;
        end else begin
          code_next  = tkh_pkg::ST_REJECTED;
          state_next = S_FIN;
        end
      end
      S_SIFT_RL: begin
        if (lpos >= {1'b0, lim}) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = pos[IW-1:0];
          cmd.wr_sel  = tkh_pkg::WS_CUR;
          state_next  = S_FIN;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = lpos[IW-1:0];
          state_next  = S_SIFT_CL;
        end
      end
      S_SIFT_CL: begin
        cmd.lreg_ld = 1'b1;
        if (rpos < {1'b0, lim}) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = rpos[IW-1:0];
        end
        state_next = S_SIFT_CR;
      end
      S_SIFT_CR: begin
        // Right child wins ties between two smaller children.
        lsm         = stat.cur_gt_l;
        rsm         = (rpos < {1'b0, lim}) && stat.cur_gt_rd;
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = pos[IW-1:0];
        if (lsm && (!rsm || stat.l_lt_rd)) begin
          cmd.wr_sel = tkh_pkg::WS_LEFT;
          pos_next   = lpos;
          state_next = S_SIFT_RL;
        end else if (rsm) begin
          cmd.wr_sel = tkh_pkg::WS_RDATA;
          pos_next   = rpos;
          state_next = S_SIFT_RL;
        end else begin
          cmd.wr_sel = tkh_pkg::WS_CUR;
          state_next = S_FIN;
        end
      end
      S_SORT_RI: begin
        if (idx < held) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = idx[IW-1:0];
          state_next  = S_SORT_LI;
        end else begin
          state_next = S_FIN;
        end
      end
      S_SORT_LI: begin
        cmd.cur_ld  = 1'b1;
        cmd.cur_sel = tkh_pkg::CS_RDATA;
        jdx_next    = idx;
        state_next  = S_SORT_RJ;
      end
      S_SORT_RJ: begin
        if (jdx == '0) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = '0;
          cmd.wr_sel  = tkh_pkg::WS_CUR;
          idx_next    = idx + CW'(1);
          state_next  = S_SORT_RI;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = IW'(jdx - CW'(1));
          state_next  = S_SORT_CJ;
        end
      end
      S_SORT_CJ: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = jdx[IW-1:0];
        if (stat.rd_gt_cur) begin
          cmd.wr_sel = tkh_pkg::WS_RDATA;
          jdx_next   = jdx - CW'(1);
          state_next = S_SORT_RJ;
        end else begin
          cmd.wr_sel = tkh_pkg::WS_CUR;
          idx_next   = idx + CW'(1);
          state_next = S_SORT_RI;
        end
      end
      S_FIN: begin
        if (!stat.out_full) begin
          cmd.out_ld     = 1'b1;
          cmd.out_rd     = rdout;
          cmd.out_status = code;
          cmd.out_count  = held;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cap   <= CW'(16);
      held  <= '0;
      idx   <= '0;
      jdx   <= '0;
      pos   <= '0;
      lim   <= '0;
      code  <= tkh_pkg::ST_REJECTED;
      rdout <= 1'b0;
    end else begin
      state <= state_next;
      held  <= held_next;
      idx   <= idx_next;
      jdx   <= jdx_next;
      pos   <= pos_next;
      lim   <= lim_next;
      code  <= code_next;
      rdout <= rdout_next;
      if (cfg_we) begin
        cap <= cfg_data;
      end
    end
  end

endmodule

// ===== hdl/tkh_checker.sv =====
// Port-level checker for the top-K store, bound to the top level.
// Depends on tkh_pkg.
module tkh_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [231:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[4:0] <= 5'd16)
    else $error("entry count above capacity");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == tkh_pkg::ST_CLEARED |-> m_axis_tdata[4:0] == 5'd0)
    else $error("clear left entries");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != tkh_pkg::ST_READ_OK |-> m_axis_tdata[231:5] == '0)
    else $error("entry fields set without a read");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while busy");

endmodule

bind top_k_heap_with_dedup tkh_checker u_tkh_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

// ===== tb/sv/top_k_heap_with_dedup_test.sv =====
// Self-checking testbench for the top-K selection store with duplicate merging.
// Drives items over the input stream, predicts every result and checks the output stream.
// Depends on tkh_pkg and top_k_heap_with_dedup.
module top_k_heap_with_dedup_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  act;
    logic [63:0] tag;
    logic [63:0] modk;
    logic [31:0] ml;
    logic [31:0] mr;
    logic [31:0] sc;
    logic [3:0]  ri;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  count;
    logic [63:0] tag;
    logic [63:0] modk;
    logic [31:0] ml;
    logic [31:0] mr;
    logic [31:0] sc;
  } rsp_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [4:0] cfg_data = 0;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [231:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [231:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;

  top_k_heap_with_dedup uut (.*);

  initial forever #5 clk = ~clk;

  // Predictor state.
  tkh_pkg::entry_t store [tkh_pkg::CAPACITY];
  int held = 0;
  logic [4:0] cap_reg = 5'd16;

  req_t pending[$];
  rsp_t awaited[$];
  int errors = 0, n_results = 0, cycles = 0;
  int send_idle = 0, recv_stall = 0;
  bit hold_off = 0;

  function automatic void enqueue(req_t q);
    pending = {pending, q};
  endfunction

  function automatic int cap_k();
    int k;
    k = cap_reg;
    if (k < 2) k = 2;
    if (k > tkh_pkg::CAPACITY) k = tkh_pkg::CAPACITY;
    return k;
  endfunction

  function automatic void sift(int pos, int k);
    int l, r, nx;
    bit lsm, rsm;
    tkh_pkg::entry_t t;
    while (pos < k) begin
      l = pos * 2 + 1;
      r = l + 1;
      lsm = (l < k) && store[pos].score > store[l].score;
      rsm = (r < k) && store[pos].score > store[r].score;
      if (lsm && rsm) nx = (store[l].score < store[r].score) ? l : r;
      else if (lsm) nx = l;
      else if (rsm) nx = r;
      else break;
      t = store[pos]; store[pos] = store[nx]; store[nx] = t;
      pos = nx;
    end
  endfunction

  function automatic rsp_t predict_store(req_t q);
    rsp_t o;
    int k, j;
    bit found;
    tkh_pkg::entry_t e, t;
    o = '0;
    k = cap_k();
    e.tag_key = q.tag; e.mod_key = q.modk; e.mass_left = q.ml;
    e.mass_right = q.mr; e.score = q.sc;
    o.status = tkh_pkg::ST_REJECTED;
    if (q.act == tkh_pkg::ACT_PUSH) begin
      found = 0;
      for (int i = 0; i < held; i++) begin
        if (store[i].tag_key == q.tag && store[i].mod_key == q.modk &&
            store[i].mass_left == q.ml && store[i].mass_right == q.mr) begin
          found = 1;
          if (store[i].score < q.sc) begin
            store[i].score = q.sc;
            if (held >= k) sift(i, k);
            o.status = tkh_pkg::ST_RAISED;
          end else o.status = tkh_pkg::ST_KEPT;
          break;
        end
      end
      if (!found) begin
        if (held < k) begin
          store[held] = e;
          held++;
          if (held == k)
            for (int i = 1; i < held; i++) begin
              j = i;
              while (j > 0 && store[j-1].score > store[j].score) begin
                t = store[j-1]; store[j-1] = store[j]; store[j] = t;
                j--;
              end
            end
          o.status = tkh_pkg::ST_APPENDED;
        end else if (q.sc > store[0].score) begin
          store[0] = e;
          sift(0, k);
          o.status = tkh_pkg::ST_REPLACED;
        end
      end
    end else if (q.act == tkh_pkg::ACT_CLEAR) begin
      held = 0;
      o.status = tkh_pkg::ST_CLEARED;
    end else if (q.act == tkh_pkg::ACT_READ) begin
      if (q.ri < held) begin
        o.tag = store[q.ri].tag_key; o.modk = store[q.ri].mod_key;
        o.ml = store[q.ri].mass_left; o.mr = store[q.ri].mass_right;
        o.sc = store[q.ri].score;
        o.status = tkh_pkg::ST_READ_OK;
      end else o.status = tkh_pkg::ST_BAD_IDX;
    end
    o.count = held[4:0];
    return o;
  endfunction

  // Driver: the predictor runs when the item is accepted.
  always @(posedge clk) begin
    req_t acc;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        acc = pending.pop_front();
        awaited = {awaited, predict_store(acc)};
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (pending.size() > 0 && !hold_off && $urandom_range(99) >= send_idle) begin
          s_axis_tvalid <= 1;
          s_axis_tdata <= {4'b0000, pending[0].ri, pending[0].sc, pending[0].mr,
                           pending[0].ml, pending[0].modk, pending[0].tag};
          s_axis_tuser <= pending[0].act;
        end else s_axis_tvalid <= 0;
      end
    end
  end

  // Note: the driver peeks pending[0]; the item popped on acceptance is the one shown.
  // Monitor.
  always @(posedge clk) begin
    rsp_t got, want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser;
        {got.sc, got.mr, got.ml, got.modk, got.tag, got.count} = m_axis_tdata[228:0];
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = awaited.pop_front();
          n_results++;
          if (got !== want || m_axis_tdata[231:229] !== 3'b0) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
      cycles++;
      if (cycles > 2000000) begin
        $display("top_k_heap_with_dedup test failed");
        $finish;
      end
    end
  end

  function automatic req_t mk(logic [1:0] a, logic [63:0] t, logic [63:0] m,
                              logic [31:0] l, logic [31:0] r, logic [31:0] s,
                              logic [3:0] i);
    req_t q;
    q.act = a; q.tag = t; q.modk = m; q.ml = l; q.mr = r; q.sc = s; q.ri = i;
    return q;
  endfunction

  function automatic logic [63:0] r64();
    return {$urandom, $urandom};
  endfunction

  // Pool of identities so that duplicates occur often.
  req_t pool[8];

  function automatic req_t rand_item();
    req_t q;
    int p;
    p = $urandom_range(99);
    if (p < 55) begin
      q = pool[$urandom_range(7)];
      q.act = tkh_pkg::ACT_PUSH;
      q.sc = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40);
    end else if (p < 70)
      q = mk(tkh_pkg::ACT_PUSH, r64(), r64(), $urandom, $urandom,
             ($urandom_range(1) ? $urandom : $urandom_range(40)), 0);
    else if (p < 90) q = mk(tkh_pkg::ACT_READ, r64(), r64(), $urandom, $urandom, $urandom,
                            $urandom_range(15));
    else if (p < 96) q = mk(tkh_pkg::ACT_CLEAR, r64(), r64(), $urandom, $urandom, $urandom,
                            $urandom_range(15));
    else q = mk(tkh_pkg::ACT_UNUSED, r64(), r64(), $urandom, $urandom, $urandom,
                $urandom_range(15));
    return q;
  endfunction

  task automatic drain();
    while (pending.size() > 0 || awaited.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_cap(logic [4:0] v);
    drain();
    @(posedge clk);
    cfg_we <= 1; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    cap_reg = v;
  endtask

  logic [4:0] caps[6] = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd5, 5'd9};

  initial begin
    for (int i = 0; i < 8; i++)
      pool[i] = mk(tkh_pkg::ACT_PUSH, r64(), r64(), $urandom, $urandom, 0, 0);
    repeat (3) @(posedge clk);
    rst <= 0;
    // Directed: extremes, ties, duplicates, bad index and the unused action.
    enqueue(mk(tkh_pkg::ACT_READ, 0, 0, 0, 0, 0, 0));
    enqueue(mk(tkh_pkg::ACT_PUSH, '1, '1, '1, '1, '1, 0));
    enqueue(mk(tkh_pkg::ACT_PUSH, '1, '1, '1, '1, 5, 0));
    enqueue(mk(tkh_pkg::ACT_PUSH, 0, 0, 0, 0, 0, 0));
    enqueue(mk(tkh_pkg::ACT_PUSH, 0, 0, 0, 0, 7, 0));
    enqueue(mk(tkh_pkg::ACT_PUSH, 1, 0, 0, 0, 7, 0));
    enqueue(mk(tkh_pkg::ACT_UNUSED, '1, '1, '1, '1, '1, '1));
    for (int i = 0; i < 4; i++) enqueue(mk(tkh_pkg::ACT_READ, 0, 0, 0, 0, 0, i));
    enqueue(mk(tkh_pkg::ACT_READ, 0, 0, 0, 0, 0, 4'hF));
    enqueue(mk(tkh_pkg::ACT_CLEAR, '1, '1, '1, '1, '1, '1));
    set_cap(5'd3);
    enqueue(mk(tkh_pkg::ACT_PUSH, 10, 0, 0, 0, 9, 0));
    enqueue(mk(tkh_pkg::ACT_PUSH, 11, 0, 0, 0, 9, 0));
    enqueue(mk(tkh_pkg::ACT_PUSH, 12, 0, 0, 0, 9, 0));
    enqueue(mk(tkh_pkg::ACT_PUSH, 13, 0, 0, 0, 9, 0));
    enqueue(mk(tkh_pkg::ACT_PUSH, 13, 0, 0, 0, 10, 0));
    enqueue(mk(tkh_pkg::ACT_PUSH, 10, 0, 0, 0, 12, 0));
    enqueue(mk(tkh_pkg::ACT_PUSH, 10, 0, 0, 0, 1, 0));
    for (int i = 0; i < 3; i++) enqueue(mk(tkh_pkg::ACT_READ, 0, 0, 0, 0, 0, i));
    // Lowering K below the count leaves the store full with extra slots readable.
    set_cap(5'd2);
    enqueue(mk(tkh_pkg::ACT_PUSH, 14, 0, 0, 0, 100, 0));
    enqueue(mk(tkh_pkg::ACT_READ, 0, 0, 0, 0, 0, 2));
    for (int ph = 0; ph < 6; ph++) begin
      set_cap(caps[ph]);
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 50; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 50; end
        default: begin send_idle = 23; recv_stall = 23; end
      endcase
      for (int i = 0; i < 175; i++) begin
        enqueue(rand_item());
        if (i == 80 && ph == 1) begin
          // Hold the sender until the output side has caught up completely.
          while (pending.size() > 0) @(posedge clk);
          hold_off = 1;
          while (awaited.size() > 0) @(posedge clk);
          hold_off = 0;
        end
      end
    end
    drain();
    $display("Checked %0d results over six capacity settings, duplicates, reads and clears.",
             n_results);
    if (errors == 0) $display("top_k_heap_with_dedup test passed");
    else $display("top_k_heap_with_dedup test failed");
    $finish;
  end
endmodule
